/* hw/rtl/csc_pkg.sv */
// Package: types, constants and calendar helpers for the seconds/calendar converter.
`timescale 1ns / 1ps

package csc_pkg;

    // Pipeline depth: compute stages before the output register
    localparam int NUM_PIPE = 8;

    // Calendar constants
    localparam logic [31:0] LAST_COUNT   = 32'd3155759999;  // 2099-12-31 23:59:59
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;        // 365*4+1
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [6:0]  SIXTY         = 7'd60;

    // Reciprocals for division by constants
    // count/86400 = ((count>>7) * RECIP_DAY) >> 25, low by at most one
    localparam logic [15:0] RECIP_DAY  = 16'd49710;
    // exact for x < 2^17: (x * RECIP_60A) >> 23
    localparam logic [17:0] RECIP_60A  = 18'd139811;
    // exact for x < 1440: (x * RECIP_60B) >> 17
    localparam logic [11:0] RECIP_60B  = 12'd2185;
    // exact for x < 2^16: (x * RECIP_1461) >> 27
    localparam logic [16:0] RECIP_1461 = 17'd91868;
    // exact for x < 2^16: (x * RECIP_7) >> 19
    localparam logic [16:0] RECIP_7    = 17'd74899;

    // Input request
    typedef struct packed {
        logic        mode;
        logic [31:0] count_in;
        logic [6:0]  year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } t_in_item;

    // Result
    typedef struct packed {
        logic [31:0] count_out;
        logic [6:0]  year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [2:0]  weekday_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic        range_error;
    } t_out_item;

    // Working set carried down the pipeline (p_: packing, u_: unpacking)
    typedef struct packed {
        logic        mode;
        logic [31:0] count_in;
        logic        flag;
        logic [31:0] p_md;
        logic [15:0] p_yd;
        logic [16:0] p_tod;
        logic [31:0] p_days;
        logic [31:0] p_prod;
        logic [31:0] p_count;
        logic [31:0] u_c;
        logic [15:0] u_q0;
        logic [17:0] u_rem;
        logic [15:0] u_days;
        logic [16:0] u_sod;
        logic [10:0] u_mt;
        logic [4:0]  u_q4;
        logic [12:0] u_wq;
        logic [5:0]  u_sec;
        logic [4:0]  u_hr;
        logic [10:0] u_r;
        logic [2:0]  u_wd;
        logic [5:0]  u_min;
        logic [6:0]  u_year;
        logic [8:0]  u_doy;
        logic        u_leap;
        logic [3:0]  u_month;
        logic [4:0]  u_day;
    } t_pipe;

    // Day of year at which a month starts, common year; zero for invalid months
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        unique case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Month start including the leap day after February
    function automatic logic [8:0] start_of(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        s = month_start(m);
        if (leap && m > 4'd2) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

/* hw/rtl/csc_in_if.sv */
// Request channel interface: valid/ready with a date-time or count payload.
`timescale 1ns / 1ps

interface csc_in_if;
    import csc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/csc_out_if.sv */
// Result channel interface: valid/ready with the converted fields.
`timescale 1ns / 1ps

interface csc_out_if;
    import csc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/csc_stages.sv */
// Stage logic of the converter pipeline: next value of every stage register.
`timescale 1ns / 1ps

module csc_stages (
    input  csc_pkg::t_in_item  i_item,
    input  csc_pkg::t_pipe     i_stage [csc_pkg::NUM_PIPE],
    output csc_pkg::t_pipe     o_stage [csc_pkg::NUM_PIPE],
    output csc_pkg::t_out_item o_item
);
    import csc_pkg::*;

    // Stage 0: clamp the count; month/day offset, year days and time of day
    always_comb begin : st0
        logic [8:0] ms;
        logic       corr;
        o_stage[0]          = '0;
        o_stage[0].mode     = i_item.mode;
        o_stage[0].count_in = i_item.count_in;
        o_stage[0].flag     = (i_item.count_in > LAST_COUNT);
        o_stage[0].u_c      = o_stage[0].flag ? LAST_COUNT : i_item.count_in;
        ms   = month_start(i_item.month_in);
        corr = (i_item.year_in[1:0] == 2'b00) && (i_item.month_in <= 4'd2);
        if (i_item.month_in >= 4'd1 && i_item.month_in <= 4'd12) begin
            o_stage[0].p_md = 32'(ms) + 32'(i_item.day_in) - 32'd1 - 32'(corr);
        end
        // days before this year, plus one for the leap day of year zero
        o_stage[0].p_yd  = 16'(i_item.year_in) * DAYS_PER_YEAR
                         + 16'(i_item.year_in[6:2]) + 16'd1;
        o_stage[0].p_tod = 17'(i_item.hour_in) * 17'(SECS_PER_HOUR)
                         + 17'(i_item.minute_in) * 17'(SIXTY)
                         + 17'(i_item.second_in);
    end

    // Stage 1: total days for packing; day estimate for unpacking
    always_comb begin : st1
        logic [40:0] prod;
        o_stage[1]        = i_stage[0];
        o_stage[1].p_days = 32'(i_stage[0].p_yd) + i_stage[0].p_md;
        prod              = 41'(i_stage[0].u_c[31:7]) * 41'(RECIP_DAY);
        o_stage[1].u_q0   = prod[40:25];
    end

    // Stage 2: days to seconds; remainder against the day estimate
    always_comb begin : st2
        logic [31:0] back;
        o_stage[2]        = i_stage[1];
        o_stage[2].p_prod = i_stage[1].p_days * 32'(SECS_PER_DAY);
        back              = 32'(i_stage[1].u_q0) * 32'(SECS_PER_DAY);
        o_stage[2].u_rem  = 18'(i_stage[1].u_c - back);
    end

    // Stage 3: final packed count; correct the day estimate by one
    always_comb begin : st3
        o_stage[3]         = i_stage[2];
        o_stage[3].p_count = i_stage[2].p_prod + 32'(i_stage[2].p_tod);
        if (i_stage[2].u_rem >= 18'(SECS_PER_DAY)) begin
            o_stage[3].u_days = i_stage[2].u_q0 + 16'd1;
            o_stage[3].u_sod  = 17'(i_stage[2].u_rem - 18'(SECS_PER_DAY));
        end else begin
            o_stage[3].u_days = i_stage[2].u_q0;
            o_stage[3].u_sod  = 17'(i_stage[2].u_rem);
        end
    end

    // Stage 4: minutes of day, four-year blocks, weeks
    always_comb begin : st4
        logic [34:0] pm;
        logic [32:0] pq;
        logic [32:0] pw;
        o_stage[4]      = i_stage[3];
        pm              = 35'(i_stage[3].u_sod) * 35'(RECIP_60A);
        pq              = 33'(i_stage[3].u_days) * 33'(RECIP_1461);
        pw              = 33'(i_stage[3].u_days + 16'd5) * 33'(RECIP_7);
        o_stage[4].u_mt = pm[33:23];
        o_stage[4].u_q4 = pq[31:27];
        o_stage[4].u_wq = pw[31:19];
    end

    // Stage 5: seconds, hours, day within the block, weekday
    always_comb begin : st5
        logic [22:0] ph;
        logic [15:0] d5;
        logic [15:0] w7;
        o_stage[5]       = i_stage[4];
        o_stage[5].u_sec = 6'(i_stage[4].u_sod - 17'(i_stage[4].u_mt) * 17'(SIXTY));
        ph               = 23'(i_stage[4].u_mt) * 23'(RECIP_60B);
        o_stage[5].u_hr  = ph[21:17];
        o_stage[5].u_r   = 11'(i_stage[4].u_days
                              - 16'(i_stage[4].u_q4) * 16'(DAYS_PER_QUAD));
        d5               = i_stage[4].u_days + 16'd5;
        w7               = d5 - 16'(i_stage[4].u_wq) * 16'd7;
        o_stage[5].u_wd  = 3'(w7) + 3'd1;
    end

    // Stage 6: minutes; year and day of year inside the four-year block
    always_comb begin : st6
        logic [10:0] t;
        logic [6:0]  base;
        o_stage[6]       = i_stage[5];
        o_stage[6].u_min = 6'(i_stage[5].u_mt - 11'(i_stage[5].u_hr) * 11'(SIXTY));
        base             = {i_stage[5].u_q4, 2'b00};
        t                = i_stage[5].u_r - 11'd366;
        priority if (i_stage[5].u_r < 11'd366) begin
            o_stage[6].u_year = base;
            o_stage[6].u_doy  = 9'(i_stage[5].u_r);
            o_stage[6].u_leap = 1'b1;
        end else if (t >= 11'd730) begin
            o_stage[6].u_year = base + 7'd3;
            o_stage[6].u_doy  = 9'(t - 11'd730);
            o_stage[6].u_leap = 1'b0;
        end else if (t >= 11'd365) begin
            o_stage[6].u_year = base + 7'd2;
            o_stage[6].u_doy  = 9'(t - 11'd365);
            o_stage[6].u_leap = 1'b0;
        end else begin
            o_stage[6].u_year = base + 7'd1;
            o_stage[6].u_doy  = 9'(t);
            o_stage[6].u_leap = 1'b0;
        end
    end

    // Stage 7: month search over the twelve starts, then day of month
    always_comb begin : st7
        logic [3:0] month;
        logic [8:0] st;
        logic [8:0] s;
        o_stage[7] = i_stage[6];
        month      = 4'd1;
        st         = 9'd0;
        for (int m = 2; m <= 12; m++) begin
            s = start_of(4'(m), i_stage[6].u_leap);
            if (i_stage[6].u_doy >= s) begin
                month = 4'(m);
                st    = s;
            end
        end
        o_stage[7].u_month = month;
        o_stage[7].u_day   = 5'(i_stage[6].u_doy - st + 9'd1);
    end

    // Output: select the result of the requested direction
    always_comb begin : stout
        o_item = '0;
        if (!i_stage[NUM_PIPE-1].mode) begin
            o_item.count_out = i_stage[NUM_PIPE-1].p_count;
        end else begin
            o_item.count_out   = i_stage[NUM_PIPE-1].count_in;
            o_item.year_out    = i_stage[NUM_PIPE-1].u_year;
            o_item.month_out   = i_stage[NUM_PIPE-1].u_month;
            o_item.day_out     = i_stage[NUM_PIPE-1].u_day;
            o_item.weekday_out = i_stage[NUM_PIPE-1].u_wd;
            o_item.hour_out    = i_stage[NUM_PIPE-1].u_hr;
            o_item.minute_out  = i_stage[NUM_PIPE-1].u_min;
            o_item.second_out  = i_stage[NUM_PIPE-1].u_sec;
            o_item.range_error = i_stage[NUM_PIPE-1].flag;
        end
    end

endmodule

/* hw/rtl/calendar_seconds_converter.sv */
// Top level: pipelined converter between a seconds count and calendar date-time.
//
//   Channel  Dir  Handshake     Payload
//   i_req    in   valid/ready   mode, count_in, year/month/day/hour/minute/second_in
//   o_rsp    out  valid/ready   count_out, date-time fields, weekday_out, range_error
//
// One request per cycle unless every stage is full and the output is stalled; each result
// passes through the 8 compute stages and then the output register.
// Reset clears all stage valid bits; no request is lost or repeated under stalls.
// A stage loads whenever it is empty or its successor moves, so bubbles collapse
// and requests keep being taken while a result waits at the output and a stage is empty.
`timescale 1ns / 1ps

module calendar_seconds_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csc_in_if.sink      i_req,
    csc_out_if.source   o_rsp
);
    import csc_pkg::*;

    localparam int NUM_ST = NUM_PIPE + 1;

    t_pipe              r_pipe [NUM_PIPE];
    t_pipe              n_pipe [NUM_PIPE];
    t_out_item          r_out;
    t_out_item          n_out;
    logic [NUM_ST-1:0]  r_vld;
    logic [NUM_ST-1:0]  n_vld;
    logic [NUM_ST-1:0]  adv;

    csc_stages u_stages (
        .i_item  (i_req.payload),
        .i_stage (r_pipe),
        .o_stage (n_pipe),
        .o_item  (n_out)
    );

    // Stage advance: load when empty or when the successor moves
    always_comb begin
        adv[NUM_ST-1] = !r_vld[NUM_ST-1] || o_rsp.ready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld[0] = adv[0] ? i_req.valid : r_vld[0];
        for (int k = 1; k < NUM_ST; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_PIPE; k++) begin
            if (adv[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
        if (adv[NUM_ST-1]) begin
            r_out <= n_out;
        end
    end

    assign i_req.ready   = adv[0];
    assign o_rsp.valid   = r_vld[NUM_ST-1];
    assign o_rsp.payload = r_out;

    // Input only backs up when every stage is full and the output is stalled
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_vld) && !o_rsp.ready)
        else $error("request refused while pipeline has room");

    // An item whose successor stage is empty moves on
    a_bubble_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !r_vld[1] |=> r_vld[1])
        else $error("item did not move into an empty stage");

    // Out-of-range counts saturate to the last second of 2099, a Thursday
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.payload.range_error |->
            o_rsp.payload.year_out == 7'd99 && o_rsp.payload.month_out == 4'd12 &&
            o_rsp.payload.day_out == 5'd31 && o_rsp.payload.weekday_out == 3'd4)
        else $error("range error without saturated date");

    // Time of day fields stay in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.payload.hour_out <= 5'd23 &&
            o_rsp.payload.minute_out <= 6'd59 && o_rsp.payload.second_out <= 6'd59)
        else $error("time of day out of range");

    // An unpacked date always carries a day and a weekday
    a_date_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.payload.month_out != 4'd0 |->
            o_rsp.payload.day_out != 5'd0 && o_rsp.payload.weekday_out != 3'd0)
        else $error("incomplete unpacked date");

endmodule

/* verif/testbench.sv */
// Testbench for the calendar seconds converter: directed corners, random traffic, scoreboard.
`timescale 1ns / 1ps

module testbench;
    import csc_pkg::*;

    // Request direction
    typedef enum bit {
        MODE_PACK   = 1'b0,
        MODE_UNPACK = 1'b1
    } t_mode;

    localparam int unsigned DAY_SECS   = 86400;
    localparam int unsigned YEAR_SECS  = 365 * 86400;
    localparam int unsigned QUAD_DAYS  = 365 * 4 + 1;
    localparam int unsigned FINAL_SEC  = 36525 * 86400 - 1;  // 2099-12-31 23:59:59
    localparam int unsigned FINAL_DAY  = 36524;

    // Days before the first of each month, common year
    localparam int unsigned DAYS_BEFORE [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    logic i_clk;
    logic i_rst_n;

    csc_in_if  req_if ();
    csc_out_if rsp_if ();

    calendar_seconds_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_out_item pending_results [$];
    int        error_count   = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    // Date-time to seconds count, wrapping modulo 2^32
    function automatic t_out_item pack_date(input t_in_item item);
        t_out_item    res;
        int unsigned  yr;
        int unsigned  mon;
        int unsigned  md;
        res = '0;
        yr  = 32'(item.year_in);
        mon = 32'(item.month_in);
        md  = 0;
        if (mon >= 1 && mon <= 12) begin
            md = DAYS_BEFORE[mon - 1] + item.day_in - 1;
            // Leap year: Jan/Feb sit one day earlier relative to the year term
            if ((yr & 3) == 0 && mon <= 2) begin
                md = md - 1;
            end
        end
        res.count_out = yr * YEAR_SECS + (yr / 4 + 1) * DAY_SECS + md * DAY_SECS
                      + item.hour_in * 32'd3600 + item.minute_in * 32'd60
                      + item.second_in;
        return res;
    endfunction

    // Seconds count to date-time, saturating past 2099
    function automatic t_out_item unpack_count(input t_in_item item);
        t_out_item    res;
        int unsigned  c;
        int unsigned  days;
        int unsigned  quad;
        int unsigned  rem;
        int unsigned  yr;
        int unsigned  doy;
        int unsigned  mon;
        int unsigned  start;
        bit           leap;
        res = '0;
        c   = item.count_in;
        if (c > FINAL_SEC) begin
            c = FINAL_SEC;
            res.range_error = 1'b1;
        end
        days = c / DAY_SECS;
        quad = days / QUAD_DAYS;
        rem  = days % QUAD_DAYS;
        if (rem < 366) begin
            yr   = 4 * quad;
            doy  = rem;
            leap = 1'b1;
        end else begin
            yr   = 4 * quad + 1 + (rem - 366) / 365;
            doy  = (rem - 366) % 365;
            leap = 1'b0;
        end
        // Walk down from December to the month holding this day of year
        mon = 12;
        start = DAYS_BEFORE[11] + leap;
        while (mon > 1) begin
            start = DAYS_BEFORE[mon - 1] + ((mon > 2) ? leap : 1'b0);
            if (doy >= start) begin
                break;
            end
            mon = mon - 1;
        end
        start = DAYS_BEFORE[mon - 1] + ((mon > 2) ? leap : 1'b0);
        res.count_out   = item.count_in;
        res.year_out    = yr[6:0];
        res.month_out   = mon[3:0];
        res.day_out     = 5'(doy - start + 1);
        res.weekday_out = 3'((days + 5) % 7 + 1);  // day 0 was a Saturday
        res.hour_out    = 5'((c / 3600) % 24);
        res.minute_out  = 6'((c % 3600) / 60);
        res.second_out  = 6'(c % 60);
        return res;
    endfunction

    function automatic t_out_item convert_request(input t_in_item item);
        if (item.mode == MODE_PACK) begin
            return pack_date(item);
        end
        return unpack_count(item);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Receiver: random backpressure at the current stall rate
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Scoreboard: predict on every accepted request, compare on every accepted result
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pending_results.push_back(convert_request(req_if.payload));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.payload;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, count_out %0d",
                                              got.count_out));
                end else begin
                    want = pending_results.pop_front();
                    check_field("count_out",   got.count_out,   want.count_out);
                    check_field("year_out",    32'(got.year_out),    32'(want.year_out));
                    check_field("month_out",   32'(got.month_out),   32'(want.month_out));
                    check_field("day_out",     32'(got.day_out),     32'(want.day_out));
                    check_field("weekday_out", 32'(got.weekday_out), 32'(want.weekday_out));
                    check_field("hour_out",    32'(got.hour_out),    32'(want.hour_out));
                    check_field("minute_out",  32'(got.minute_out),  32'(want.minute_out));
                    check_field("second_out",  32'(got.second_out),  32'(want.second_out));
                    check_field("range_error", 32'(got.range_error), 32'(want.range_error));
                end
            end
        end
    end

    // Send one request; returns at the edge where it is taken
    task automatic send_request(input t_in_item item);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge i_clk);
        while (!(req_if.valid && req_if.ready)) @(posedge i_clk);
    endtask

    // Date-time request; the unused count gets random bits
    function automatic t_in_item date_request(input int unsigned yr, input int unsigned mon,
                                              input int unsigned d, input int unsigned h,
                                              input int unsigned mi, input int unsigned s);
        t_in_item item;
        item.mode      = MODE_PACK;
        item.count_in  = $urandom;
        item.year_in   = yr[6:0];
        item.month_in  = mon[3:0];
        item.day_in    = d[4:0];
        item.hour_in   = h[4:0];
        item.minute_in = mi[5:0];
        item.second_in = s[5:0];
        return item;
    endfunction

    // Count request; the unused date fields get random bits
    function automatic t_in_item count_request(input int unsigned cnt);
        t_in_item item;
        item.mode      = MODE_UNPACK;
        item.count_in  = cnt;
        item.year_in   = 7'($urandom);
        item.month_in  = 4'($urandom);
        item.day_in    = 5'($urandom);
        item.hour_in   = 5'($urandom);
        item.minute_in = 6'($urandom);
        item.second_in = 6'($urandom);
        return item;
    endfunction

    function automatic t_in_item random_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0) begin
            // Mostly legal date-times, some full-width noise
            if (pick < 85) begin
                return date_request($urandom_range(0, 99), $urandom_range(1, 12),
                                    $urandom_range(1, 31), $urandom_range(0, 23),
                                    $urandom_range(0, 59), $urandom_range(0, 59));
            end
            return date_request($urandom_range(0, 127), $urandom_range(0, 15),
                                $urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 63), $urandom_range(0, 63));
        end
        if (pick < 65) begin
            return count_request($urandom_range(0, FINAL_SEC));
        end else if (pick < 80) begin
            // First or last second of a random day
            return count_request($urandom_range(0, FINAL_DAY) * DAY_SECS
                                 + ($urandom_range(0, 1) ? DAY_SECS - 1 : 0));
        end else if (pick < 88) begin
            return count_request(FINAL_SEC - 4 + $urandom_range(0, 8));
        end
        return count_request($urandom);
    endfunction

    // Packing corners: epoch, end of range, leap days, bad months, unchecked days
    task automatic test_packing_corners();
        send_request(date_request(0, 1, 1, 0, 0, 0));
        send_request(date_request(99, 12, 31, 23, 59, 59));
        send_request(date_request(0, 2, 29, 12, 30, 30));
        send_request(date_request(1, 3, 1, 0, 0, 1));
        send_request(date_request(4, 2, 28, 23, 59, 59));
        send_request(date_request(5, 0, 17, 1, 2, 3));
        send_request(date_request(6, 13, 1, 4, 5, 6));
        send_request(date_request(7, 15, 31, 7, 8, 9));
        send_request(date_request(0, 1, 0, 0, 0, 0));
        send_request(date_request(10, 4, 31, 10, 10, 10));
        send_request(date_request(127, 15, 31, 31, 63, 63));
        send_request(date_request(127, 12, 31, 31, 63, 63));
    endtask

    // Unpacking corners: range edges, leap-year days, all-ones count
    task automatic test_unpacking_corners();
        send_request(count_request(0));
        send_request(count_request(DAY_SECS - 1));
        send_request(count_request(59 * DAY_SECS));
        send_request(count_request(365 * DAY_SECS + 3661));
        send_request(count_request(366 * DAY_SECS));
        send_request(count_request((4 * 365 + 1 + 59) * DAY_SECS));
        send_request(count_request(FINAL_SEC));
        send_request(count_request(FINAL_SEC + 1));
        send_request(count_request(32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_rate,
                                       input int num_items);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        repeat (num_items) send_request(random_request());
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_packing_corners();
        test_unpacking_corners();
        test_random_traffic(0, 0, 235);
        test_random_traffic(71, 0, 235);
        test_random_traffic(0, 71, 235);
        test_random_traffic(17, 17, 235);

        // Drain the pipeline
        req_if.valid <= 1'b0;
        stall_pct    = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
